// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/ofdm2_pkg.sv -----
package ofdm2_pkg;

  localparam int NUM_POINTS   = 21;
  localparam int TWIDDLE_BITS = 16;
  localparam int OUT_FRAC     = 14;

  localparam int TwW  = TWIDDLE_BITS + 2;
  localparam int IdxW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  typedef logic signed [TwW-1:0] tw_t;

  typedef struct packed {
    tw_t re;
    tw_t im;
  } twiddle_t;

  typedef struct packed {
    logic signed [2:0] re;
    logic signed [2:0] im;
  } qam_t;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;

  localparam logic [63:0] TaylorCosDiv [1:10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };
  localparam logic [63:0] TaylorSinDiv [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  function automatic logic [63:0] isqrt_u64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem = v;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      bitv = 64'd1 << (2 * i);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // sqrt(N) * 2^30
  localparam logic [63:0] TwDen = isqrt_u64(64'(NUM_POINTS) << 56) << 2;

  function automatic longint scale_q30(longint v);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    quo = ((mag << TWIDDLE_BITS) + (TwDen >> 1)) / TwDen;
    return (v < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // Elaboration-time twiddle: quadrant plus Q30 Taylor series on the residue
  function automatic twiddle_t twiddle_at(int unsigned n);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] phi;
    logic [63:0] x2;
    logic [63:0] tc;
    logic [63:0] ts;
    longint      sc;
    longint      ss;
    longint      cr;
    longint      ci;
    twiddle_t    w;
    q   = (64'(n) * 64'd4) / NUM_POINTS;
    r   = (64'(n) * 64'd4) % NUM_POINTS;
    phi = (HalfPiQ30 * r + 64'(NUM_POINTS / 2)) / NUM_POINTS;
    x2  = (phi * phi) >> 30;
    tc  = OneQ30;
    ts  = phi;
    sc  = longint'(OneQ30);
    ss  = longint'(phi);
    for (int k = 1; k <= 10; k++) begin
      tc = ((tc * x2) >> 30) / TaylorCosDiv[k];
      ts = ((ts * x2) >> 30) / TaylorSinDiv[k];
      if ((k & 1) != 0) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    case (q[1:0])
      2'd0: begin cr = sc;  ci = ss;  end
      2'd1: begin cr = -ss; ci = sc;  end
      2'd2: begin cr = -sc; ci = -ss; end
      default: begin cr = ss; ci = -sc; end
    endcase
    w.re = tw_t'(scale_q30(cr));
    w.im = tw_t'(scale_q30(ci));
    return w;
  endfunction

  localparam twiddle_t Tw0 = twiddle_at(0);

  // b0/b1 pick magnitude, b3 sets real sign, b2 negates imag
  function automatic qam_t map_nibble(logic [3:0] nib);
    qam_t s;
    s.re = nib[0] ? 3'sd1 : 3'sd3;
    s.im = nib[1] ? 3'sd1 : 3'sd3;
    if (!nib[3]) s.re = -s.re;
    if (nib[2])  s.im = -s.im;
    return s;
  endfunction

endpackage

// ----- rtl/ofdm_two_carrier_qam16_modulator.sv -----
// Path: byte register, then ROM, product and sum stages to the output.
// Throughput: 21 samples per byte, one per cycle unless out_stall_i holds; the
// next request taken as the sample counter wraps, so symbols run back to back.
// The sample counter and the ROM-multiply-sum pipeline set that figure.
// Reset: asynchronous, active low; clears busy, the valid bits and the counter only.
`include "assert_macros.svh"

module ofdm_two_carrier_qam16_modulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [17:0]  sample_real_o,
  output logic signed [17:0]  sample_imag_o,
  output logic [5:0]          sample_index_o,
  output logic                last_sample_o
);

  localparam int IdxW = ofdm2_pkg::IdxW;
  localparam int TwW  = ofdm2_pkg::TwW;
  localparam int PW   = TwW + 3;
  localparam int AccW = PW + 2;
  localparam int ShR  = (ofdm2_pkg::TWIDDLE_BITS >= ofdm2_pkg::OUT_FRAC) ?
                        (ofdm2_pkg::TWIDDLE_BITS - ofdm2_pkg::OUT_FRAC) : 0;
  localparam int ShL  = (ofdm2_pkg::TWIDDLE_BITS < ofdm2_pkg::OUT_FRAC) ?
                        (ofdm2_pkg::OUT_FRAC - ofdm2_pkg::TWIDDLE_BITS) : 0;
  localparam int VW   = AccW + 1 + ShL;

  localparam logic [IdxW-1:0]      Last   = IdxW'(ofdm2_pkg::NUM_POINTS - 1);
  localparam logic signed [VW-1:0] Rnd    = (ShR > 0) ? VW'(1) <<< (ShR - 1) : '0;
  localparam logic signed [VW-1:0] OutMax = VW'(131071);
  localparam logic signed [VW-1:0] OutMin = -VW'(131072);
  localparam logic signed [PW-1:0] W0Re   = PW'(ofdm2_pkg::Tw0.re);

  ofdm2_pkg::twiddle_t tw_rom [ofdm2_pkg::NUM_POINTS];

  for (genvar g = 0; g < ofdm2_pkg::NUM_POINTS; g++) begin : g_rom
    assign tw_rom[g] = ofdm2_pkg::twiddle_at(g);
  end

  logic                adv;
  logic                in_acc;
  logic                busy_q, busy_d;
  logic [IdxW-1:0]     n_q, n_d;
  logic [7:0]          byte_q;

  logic                v1_q;
  logic [7:0]          byte1_q;
  ofdm2_pkg::twiddle_t w1_q;
  logic [IdxW-1:0]     n1_q;
  logic                last1_q;

  logic                v2_q;
  logic signed [PW-1:0] pa_r_q, pa_i_q, p_brwr_q, p_biwi_q, p_brwi_q, p_biwr_q;
  logic [IdxW-1:0]     n2_q;
  logic                last2_q;

  ofdm2_pkg::qam_t     sa, sb;
  logic signed [AccW-1:0] acc_r, acc_i;

  logic                out_valid_q;
  logic signed [17:0]  re_q, im_q;
  logic [IdxW-1:0]     n3_q;
  logic                last3_q;

  function automatic logic signed [17:0] to_out(logic signed [AccW-1:0] acc);
    logic signed [VW-1:0] v;
    v = VW'(acc) + Rnd;
    v = (v >>> ShR) <<< ShL;
    if (v > OutMax) v = OutMax;
    if (v < OutMin) v = OutMin;
    return v[17:0];
  endfunction

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q && !(adv && n_q == Last);
  assign in_acc     = in_valid_i && !in_stall_o;

  // sample sequencer
  always_comb begin
    busy_d = busy_q;
    n_d    = n_q;
    if (busy_q && adv) begin
      if (n_q == Last) begin
        busy_d = in_acc;
        n_d    = '0;
      end else begin
        n_d = n_q + 1'b1;
      end
    end else if (!busy_q && in_acc) begin
      busy_d = 1'b1;
      n_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      n_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      n_q    <= n_d;
      if (adv) begin
        v1_q        <= busy_q;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
    end
  end

  // stage 1: twiddle ROM
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte1_q <= byte_q;
      w1_q    <= tw_rom[n_q];
      n1_q    <= n_q;
      last1_q <= (n_q == Last);
    end
  end

  // stage 2: symbol by twiddle products
  always_comb begin
    sa = ofdm2_pkg::map_nibble(byte1_q[3:0]);
    sb = ofdm2_pkg::map_nibble(byte1_q[7:4]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_r_q   <= PW'(sa.re) * W0Re;
      pa_i_q   <= PW'(sa.im) * W0Re;
      p_brwr_q <= PW'(sb.re) * PW'(w1_q.re);
      p_biwi_q <= PW'(sb.im) * PW'(w1_q.im);
      p_brwi_q <= PW'(sb.re) * PW'(w1_q.im);
      p_biwr_q <= PW'(sb.im) * PW'(w1_q.re);
      n2_q     <= n1_q;
      last2_q  <= last1_q;
    end
  end

  // stage 3: sum, round to Q14, saturate
  always_comb begin
    acc_r = AccW'(pa_r_q) + AccW'(p_brwr_q) - AccW'(p_biwi_q);
    acc_i = AccW'(pa_i_q) + AccW'(p_brwi_q) + AccW'(p_biwr_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q    <= to_out(acc_r);
      im_q    <= to_out(acc_i);
      n3_q    <= n2_q;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_real_o  = re_q;
  assign sample_imag_o  = im_q;
  assign sample_index_o = 6'(n3_q);
  assign last_sample_o  = last3_q;

  `ASSERT_CLK(a_accept_at_wrap, clk_i, rst_ni,
    in_acc |-> (!busy_q || n_q == Last), "request taken mid-symbol")
  `ASSERT_CLK(a_last_index, clk_i, rst_ni,
    (out_valid_o && last_sample_o) |-> (n3_q == Last), "last flag on wrong index")
  `ASSERT_CLK(a_hold_counter, clk_i, rst_ni,
    !adv |=> $stable(n_q), "sample counter moved while stalled")
  `ASSERT_NEVER(a_idle_counter, clk_i, rst_ni,
    !busy_q && n_q != '0, "counter not parked while idle")

endmodule
